// File: hw/rtl/hvd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_pkg: shared types and constants of the great-circle distance pipeline
// Fixed-point formats, the CORDIC arctangent steps and the register and zone
// codes.
// ----------------------------------------------------------------------------
package hvd_pkg;

  // CORDIC datapath word: Q2.30 plus guard bits, signed.
  localparam int CW = 34;
  typedef logic signed [CW-1:0] cw_t;

  // Unsigned Q1.30 value in the range 0..1.
  typedef logic [30:0] q30_t;

  localparam q30_t Q30_ONE = 31'h4000_0000;

  // Initial x of the rotation CORDIC: inverse of the CORDIC gain in Q2.30.
  localparam cw_t CORDIC_GAIN_INV = 34'sd652032874;

  // Number of result bits of the square root (root of up to 2^60).
  localparam int SQRT_BITS = 31;
  localparam int SQRT_RW = 63;

  // Half-unit count to Q2.30 angle: pi * 2^60 / 3600000, split into halves.
  localparam logic [63:0] ANGLE_K = 64'h3243_F6A8_885A_308D / 64'd3600000;
  localparam logic [19:0] ANGLE_K_LO = ANGLE_K[19:0];
  localparam logic [19:0] ANGLE_K_HI = ANGLE_K[39:20];

  localparam logic [16:0] TWO_RADIUS_DKM = 17'd127420;
  localparam logic [17:0] DIST_MAX = 18'd200150;

  localparam logic signed [20:0] LAT_MAX = 21'sd900000;
  localparam logic signed [21:0] LON_MAX = 22'sd1800000;
  localparam logic [20:0] HALF_TURN = 21'd1800000;

  // Configuration register indexes.
  localparam logic [1:0] REG_OBS_LAT = 2'd0;
  localparam logic [1:0] REG_OBS_LON = 2'd1;
  localparam logic [1:0] REG_NEAR = 2'd2;
  localparam logic [1:0] REG_APPROACH = 2'd3;

  // Zone codes.
  localparam logic [1:0] ZONE_NEAR = 2'd0;
  localparam logic [1:0] ZONE_APPROACH = 2'd1;
  localparam logic [1:0] ZONE_FAR = 2'd2;

  localparam cw_t ATAN_TAB [10] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
    34'sd4194283, 34'sd2097149
  };

  // atan(2^-i) in Q2.30; beyond the table it equals 2^-i.
  function automatic cw_t atan_step(input int i);
    cw_t r;
    r = '0;
    if (i < 10) begin
      r = ATAN_TAB[i];
    end else if (i <= 30) begin
      r = cw_t'(64'sd1 <<< (30 - i));
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hvd_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_cordic: unrolled CORDIC, one register stage per iteration
// Works in rotation mode (driven by z) or vectoring mode (driven by y).
// ----------------------------------------------------------------------------
module hvd_cordic #(
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic          vector_mode,
  input  hvd_pkg::cw_t  x_in,
  input  hvd_pkg::cw_t  y_in,
  input  hvd_pkg::cw_t  z_in,
  output hvd_pkg::cw_t  x_out,
  output hvd_pkg::cw_t  y_out,
  output hvd_pkg::cw_t  z_out
);
  import hvd_pkg::*;

  cw_t x_q [STAGES];
  cw_t y_q [STAGES];
  cw_t z_q [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    cw_t xi, yi, zi;
    logic pos;

    if (i == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end

    // pos selects x -= y*2^-i, y += x*2^-i, z -= atan(2^-i).
    assign pos = vector_mode ? yi[CW-1] : !zi[CW-1];

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - atan_step(i);
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + atan_step(i);
        end
      end
    end
  end

  assign x_out = x_q[STAGES-1];
  assign y_out = y_q[STAGES-1];
  assign z_out = z_q[STAGES-1];

endmodule
`default_nettype wire

// File: hw/rtl/hvd_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hvd_isqrt: pipelined integer square root, floor
// One result bit per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module hvd_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [hvd_pkg::SQRT_RW-1:0]    n_in,
  output logic [hvd_pkg::SQRT_BITS-1:0]  root_out
);
  import hvd_pkg::*;

  logic [SQRT_RW-1:0] rem_q [SQRT_BITS];
  logic [SQRT_BITS-1:0] root_q [SQRT_BITS];

  for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
    localparam int K = SQRT_BITS - 1 - j;
    logic [SQRT_RW-1:0] rem_i, trial;
    logic [SQRT_BITS-1:0] root_i;

    if (j == 0) begin : g_first
      assign rem_i = n_in;
      assign root_i = '0;
    end else begin : g_next
      assign rem_i = rem_q[j-1];
      assign root_i = root_q[j-1];
    end

    // Growth of the square when bit K is set: 2*root*2^K + 2^(2K).
    assign trial = (SQRT_RW'(root_i) << (K + 1)) + (SQRT_RW'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_i >= trial) begin
          rem_q[j] <= rem_i - trial;
          root_q[j] <= root_i | (SQRT_BITS'(1) << K);
        end else begin
          rem_q[j] <= rem_i;
          root_q[j] <= root_i;
        end
      end
    end
  end

  assign root_out = root_q[SQRT_BITS-1];

endmodule
`default_nettype wire

// File: hw/rtl/haversine_distance_zone.sv
`default_nettype none
// ----------------------------------------------------------------------------
// haversine_distance_zone: great-circle distance and proximity zone
// Haversine distance from a configured observer, in 0.1 km, and its zone.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload (lowest bits first)
//  s_axis    in   tvalid/tready    target_latitude[20:0], target_longitude[42:21]
//  m_axis    out  tvalid/tready    distance[17:0], zone[19:18]
//  cfg       in   valid/ready      cfg_index selects register, cfg_data value
//
//  One item enters per cycle unless the pipeline stalls; its depth is set by the
//  two unrolled CORDIC chains and the 31-stage square root pipeline.
//  The whole pipeline advances together: it stalls only while the output
//  register holds an item that is not taken, and then s_axis_tready is low.
//  Reset clears the valid bits and loads the register reset values.
//  Configuration writes are always taken (cfg_ready is high).
// ----------------------------------------------------------------------------
module haversine_distance_zone #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // target_latitude, target_longitude
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // distance, zone
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);
  import hvd_pkg::*;

  localparam int LAT = 43 + 2 * CORDIC_STAGES;

  function automatic logic signed [20:0] clamp_lat(input logic signed [20:0] v);
    logic signed [20:0] r;
    r = v;
    if (v > LAT_MAX) r = LAT_MAX;
    else if (v < -LAT_MAX) r = -LAT_MAX;
    return r;
  endfunction

  function automatic logic signed [21:0] clamp_lon(input logic signed [21:0] v);
    logic signed [21:0] r;
    r = v;
    if (v > LON_MAX) r = LON_MAX;
    else if (v < -LON_MAX) r = -LON_MAX;
    return r;
  endfunction

  function automatic q30_t clamp_unit(input cw_t v);
    q30_t r;
    r = v[30:0];
    if (v[CW-1]) r = '0;
    else if (v > cw_t'(Q30_ONE)) r = Q30_ONE;
    return r;
  endfunction

  // Configuration registers.
  logic signed [20:0] obs_lat;
  logic signed [21:0] obs_lon;
  logic [17:0] near_radius;
  logic [17:0] approach_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      obs_lat <= '0;
      obs_lon <= '0;
      near_radius <= 18'd5000;
      approach_radius <= 18'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_OBS_LAT:  obs_lat <= cfg_data[20:0];
        REG_OBS_LON:  obs_lon <= cfg_data;
        REG_NEAR:     near_radius <= cfg_data[17:0];
        REG_APPROACH: approach_radius <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic en;
  logic [LAT-1:0] vld;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  // Stage 0: clamped coordinates.
  logic signed [20:0] lat1, lat2;
  logic signed [21:0] lon1, lon2;

  always_ff @(posedge clk) begin
    if (en) begin
      lat1 <= clamp_lat(obs_lat);
      lon1 <= clamp_lon(obs_lon);
      lat2 <= clamp_lat(s_axis_tdata[20:0]);
      lon2 <= clamp_lon(s_axis_tdata[42:21]);
    end
  end

  // Stage 1: half-angle counts. Index 0 dlat, 1 dlon, 2 lat1, 3 lat2.
  logic signed [21:0] dlat_s;
  logic signed [22:0] dlon_s;
  logic [21:0] dlat_a;
  logic [22:0] dlon_a;
  logic [20:0] half [4];

  always_comb begin
    dlat_s = 22'(lat2) - 22'(lat1);
    dlon_s = 23'(lon2) - 23'(lon1);
    dlat_a = dlat_s[21] ? 22'(-dlat_s) : dlat_s;
    dlon_a = dlon_s[22] ? 23'(-dlon_s) : dlon_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half[0] <= dlat_a[20:0];
      if (dlon_a > 23'(HALF_TURN)) begin
        half[1] <= 21'((23'(HALF_TURN) << 1) - dlon_a);
      end else begin
        half[1] <= dlon_a[20:0];
      end
      half[2] <= lat1[20] ? 21'(-lat1) << 1 : 21'(lat1) << 1;
      half[3] <= lat2[20] ? 21'(-lat2) << 1 : 21'(lat2) << 1;
    end
  end

  // Stages 2 and 3: count times K, rounded to a Q2.30 angle.
  logic [40:0] prod_hi [4];
  logic [40:0] prod_lo [4];
  cw_t angle [4];
  cw_t rot_x [4];
  cw_t rot_y [4];

  for (genvar a = 0; a < 4; a++) begin : g_angle
    logic [61:0] sum;
    cw_t unused_z;

    assign sum = {1'b0, prod_hi[a], 20'd0} + 62'(prod_lo[a]) + (62'd1 << 29);

    always_ff @(posedge clk) begin
      if (en) begin
        prod_hi[a] <= 41'(half[a]) * 41'(ANGLE_K_HI);
        prod_lo[a] <= 41'(half[a]) * 41'(ANGLE_K_LO);
        angle[a] <= cw_t'(sum[60:30]);
      end
    end

    hvd_cordic #(.STAGES(CORDIC_STAGES)) u_rot (
      .clk         (clk),
      .en          (en),
      .vector_mode (1'b0),
      .x_in        (CORDIC_GAIN_INV),
      .y_in        ('0),
      .z_in        (angle[a]),
      .x_out       (rot_x[a]),
      .y_out       (rot_y[a]),
      .z_out       (unused_z)
    );
  end

  // Clamp sines and cosines, then the haversine products.
  q30_t s1, s2, c1, c2;
  q30_t sq1_m1, t1, c1_m1, c2_m1;
  q30_t sq1_m2, t2, c2_m2;
  q30_t sq1_m3, t3;
  q30_t hav;
  logic [61:0] p_sq1, p_t1, p_t2, p_t3;
  logic [31:0] hav_sum;

  assign p_sq1 = 62'(s1) * 62'(s1);
  assign p_t1 = 62'(s2) * 62'(s2);
  assign p_t2 = 62'(t1) * 62'(c1_m1);
  assign p_t3 = 62'(t2) * 62'(c2_m2);
  assign hav_sum = 32'(sq1_m3) + 32'(t3);

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= clamp_unit(rot_y[0]);
      s2 <= clamp_unit(rot_y[1]);
      c1 <= clamp_unit(rot_x[2]);
      c2 <= clamp_unit(rot_x[3]);

      sq1_m1 <= p_sq1[60:30];
      t1 <= p_t1[60:30];
      c1_m1 <= c1;
      c2_m1 <= c2;

      sq1_m2 <= sq1_m1;
      t2 <= p_t2[60:30];
      c2_m2 <= c2_m1;

      sq1_m3 <= sq1_m2;
      t3 <= p_t3[60:30];

      hav <= (hav_sum > 32'(Q30_ONE)) ? Q30_ONE : hav_sum[30:0];
    end
  end

  // Square roots of a and 1 - a, then the angle between them.
  logic [SQRT_RW-1:0] n_y, n_x;
  q30_t comp;
  logic [SQRT_BITS-1:0] root_y, root_x;
  cw_t vec_z, unused_vx, unused_vy;

  assign comp = Q30_ONE - hav;
  assign n_y = SQRT_RW'(hav) << 30;
  assign n_x = SQRT_RW'(comp) << 30;

  hvd_isqrt u_sqrt_y (
    .clk      (clk),
    .en       (en),
    .n_in     (n_y),
    .root_out (root_y)
  );

  hvd_isqrt u_sqrt_x (
    .clk      (clk),
    .en       (en),
    .n_in     (n_x),
    .root_out (root_x)
  );

  hvd_cordic #(.STAGES(CORDIC_STAGES)) u_vec (
    .clk         (clk),
    .en          (en),
    .vector_mode (1'b1),
    .x_in        (cw_t'(root_x)),
    .y_in        (cw_t'(root_y)),
    .z_in        ('0),
    .x_out       (unused_vx),
    .y_out       (unused_vy),
    .z_out       (vec_z)
  );

  // Angle to distance, saturation and zone.
  logic [30:0] theta;
  logic [47:0] dist_prod;
  logic [47:0] dist_round;
  logic [17:0] dist_sat;
  logic [17:0] out_dist;
  logic [1:0] out_zone;

  assign dist_round = dist_prod + (48'd1 << 29);
  assign dist_sat = (dist_round[47:30] > DIST_MAX) ? DIST_MAX : dist_round[47:30];

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= vec_z[CW-1] ? '0 : vec_z[30:0];
      dist_prod <= 48'(theta) * 48'(TWO_RADIUS_DKM);
      out_dist <= dist_sat;
      if (dist_sat <= near_radius) begin
        out_zone <= ZONE_NEAR;
      end else if (dist_sat <= approach_radius) begin
        out_zone <= ZONE_APPROACH;
      end else begin
        out_zone <= ZONE_FAR;
      end
    end
  end

  assign m_axis_tdata = {4'd0, out_zone, out_dist};

endmodule
`default_nettype wire

// File: dv/tb_haversine_distance_zone.sv
// ----------------------------------------------------------------------------
// tb_haversine_distance_zone: self-checking testbench of the distance block
// Positions go in on the input stream. Each one is scored against a
// bit-accurate fixed-point model of the haversine pipeline: CORDIC sine and
// cosine, integer square roots and a vectoring CORDIC. Random idle cycles on
// both streams, a long output hold-off, and register changes between phases.
// ----------------------------------------------------------------------------
module tb_haversine_distance_zone;
  import hvd_pkg::*;

  localparam int STAGES = 16;
  localparam longint unsigned PI_Q60_K = 64'h3243_F6A8_885A_308D / 64'd3600000;
  localparam longint ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [17:0] dist_dkm;
    logic [1:0]  zone;
  } fix_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // target_latitude[20:0], target_longitude[42:21]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // distance[17:0], zone[19:18]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [21:0] cfg_data;

  haversine_distance_zone #(.CORDIC_STAGES(STAGES)) uut (.*);

  // Register copies, kept at the widths of the block's registers.
  logic [20:0] obs_lat_reg;
  logic [21:0] obs_lon_reg;
  logic [17:0] near_reg;
  logic [17:0] approach_reg;

  fix_t expected_fixes[$];
  int   errors;
  bit   steady_send;
  bit   steady_recv;
  int   hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic longint arc_step(input int i);
    longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tab[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of a count of 0.5e-4 degree.
  function automatic void sin_cos(input longint half_units, output longint s,
                                  output longint c);
    longint x, y, z, dx, dy;
    z = longint'((longint'(half_units) * PI_Q60_K + (64'd1 << 29)) >> 30);
    x = 652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    s = clamp(y, 0, ONE_Q30);
    c = clamp(x, 0, ONE_Q30);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic fix_t distance_to(input logic [20:0] lat_raw, input logic [21:0] lon_raw);
    longint lat1, lon1, lat2, lon2, dlat, dlon;
    longint s1, s2, c1, c2, junk, x, y, z, dx, dy, dist_val;
    longint unsigned t, a;
    fix_t f;
    lat1 = clamp(longint'($signed(obs_lat_reg)), -900000, 900000);
    lon1 = clamp(longint'($signed(obs_lon_reg)), -1800000, 1800000);
    lat2 = clamp(longint'($signed(lat_raw)), -900000, 900000);
    lon2 = clamp(longint'($signed(lon_raw)), -1800000, 1800000);
    dlat = lat2 - lat1;
    dlon = lon2 - lon1;
    if (dlat < 0) dlat = -dlat;
    if (dlon < 0) dlon = -dlon;
    // Going the other way round the globe gives the same sin^2.
    if (dlon > 1800000) dlon = 3600000 - dlon;
    if (lat1 < 0) lat1 = -lat1;
    if (lat2 < 0) lat2 = -lat2;
    sin_cos(dlat, s1, junk);
    sin_cos(dlon, s2, junk);
    sin_cos(2 * lat1, junk, c1);
    sin_cos(2 * lat2, junk, c2);
    t = (longint'(s2) * s2) >> 30;
    t = (t * c1) >> 30;
    t = (t * c2) >> 30;
    a = ((longint'(s1) * s1) >> 30) + t;
    if (a > ONE_Q30) a = ONE_Q30;
    x = longint'(int_sqrt((ONE_Q30 - a) << 30));
    y = longint'(int_sqrt(a << 30));
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arc_step(i);
      end else begin
        x -= dx; y += dy; z -= arc_step(i);
      end
    end
    if (z < 0) z = 0;
    dist_val = (z * 2 * 63710 + (longint'(1) << 29)) >>> 30;
    if (dist_val > 200150) dist_val = 200150;
    f.dist_dkm = dist_val[17:0];
    if (f.dist_dkm <= near_reg) f.zone = ZONE_NEAR;
    else if (f.dist_dkm <= approach_reg) f.zone = ZONE_APPROACH;
    else f.zone = ZONE_FAR;
    return f;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_position(input logic [20:0] lat, input logic [21:0] lon);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, lon, lat};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
    expected_fixes.push_back(distance_to(lat, lon));
  endtask

  // Waits until every expected result is back and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_fixes.size() != 0) @(posedge clk);
    repeat (90) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [1:0] idx, input logic [21:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_OBS_LAT:  obs_lat_reg  = val[20:0];
      REG_OBS_LON:  obs_lon_reg  = val;
      REG_NEAR:     near_reg     = val[17:0];
      REG_APPROACH: approach_reg = val[17:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input int olat, input int olon, input int nr, input int ar);
    drain();
    write_reg(REG_OBS_LAT, 22'(olat));
    write_reg(REG_OBS_LON, 22'(olon));
    write_reg(REG_NEAR, 22'(nr));
    write_reg(REG_APPROACH, 22'(ar));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [21:0] rand_lon();
    return 22'($signed($urandom_range(0, 3600000)) - 1800000);
  endfunction

  function automatic logic [20:0] rand_lat();
    return 21'($signed($urandom_range(0, 1800000)) - 900000);
  endfunction

  // Mostly legal positions, some near the observer, some raw bit patterns.
  task automatic send_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) steady_send = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) send_position(rand_lat(), rand_lon());
      else if (pick < 8)
        send_position(obs_lat_reg + 21'($signed($urandom_range(0, 40000)) - 20000),
                      obs_lon_reg + 22'($signed($urandom_range(0, 40000)) - 20000));
      else send_position(21'($urandom), 22'($urandom));
    end
    steady_send = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int rx_wait;
    rx_wait = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_axis_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        if (m_axis_tvalid && m_axis_tready && !steady_recv) rx_wait = $urandom_range(0, 10);
        m_axis_tready <= (rx_wait == 0);
      end
    end
  end

  always @(posedge clk) begin
    fix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_fixes.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual %h", $time, m_axis_tdata);
      end else begin
        want = expected_fixes.pop_front();
        if (m_axis_tdata[17:0] !== want.dist_dkm) begin
          errors++;
          $display("%0t distance mismatch: expected %0d, actual %0d", $time,
                   want.dist_dkm, m_axis_tdata[17:0]);
        end
        if (m_axis_tdata[19:18] !== want.zone) begin
          errors++;
          $display("%0t zone mismatch: expected %0d, actual %0d", $time,
                   want.zone, m_axis_tdata[19:18]);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_extremes();
    send_position(21'd0, 22'd0);
    send_position(21'sd900000, 22'd0);
    send_position(-21'sd900000, 22'd0);
    send_position(21'd0, 22'sd1800000);
    send_position(21'd0, -22'sd1800000);
    send_position(21'd0, 22'sd900000);
    send_position(21'sd450000, -22'sd1350000);
    send_position(21'sd900000, 22'sd1800000);
    // Saturation of out-of-range coordinates.
    send_position(21'h0F_FFFF, 22'h1F_FFFF);
    send_position(21'h10_0000, 22'h20_0000);
    send_position(21'h1F_FFFF, 22'h3F_FFFF);
    set_all(900000, 1800000, 5000, 10000);
    send_position(-21'sd900000, -22'sd1800000);
    send_position(21'sd900000, -22'sd1800000);
    send_position(21'd0, 22'd0);
    set_all(-1048576, -2097152, 5000, 10000);
    send_position(21'd0, 22'd0);
    send_position(-21'sd900000, 22'sd1800000);
    send_position(21'sd1000, 22'sd1800000);
    set_all(1048575, 2097151, 5000, 10000);
    send_position(21'd0, 22'd0);
    send_position(21'sd899000, 22'sd1799000);
  endtask

  // Puts one distance exactly on each threshold.
  task automatic test_zone_edges();
    fix_t f;
    set_all(123456, -654321, 5000, 10000);
    f = distance_to(21'sd150000, -22'sd600000);
    set_all(123456, -654321, f.dist_dkm, f.dist_dkm + 1);
    send_position(21'sd150000, -22'sd600000);
    set_all(123456, -654321, f.dist_dkm - 1, f.dist_dkm);
    send_position(21'sd150000, -22'sd600000);
    set_all(123456, -654321, f.dist_dkm - 1, f.dist_dkm - 1);
    send_position(21'sd150000, -22'sd600000);
    // Approach below near, then thresholds at and past the distance range.
    set_all(0, 0, 20000, 100);
    send_random(20);
    set_all(0, 0, 0, 0);
    send_random(20);
    set_all(0, 0, 0, 200150);
    send_random(20);
    set_all(0, 0, 262143, 262143);
    send_random(20);
    set_all(0, 0, 200149, 200150);
    send_position(21'd0, 22'sd1800000);
  endtask

  task automatic test_random_sets();
    for (int k = 0; k < 8; k++) begin
      set_all($signed($urandom_range(0, 1800000)) - 900000,
              $signed($urandom_range(0, 3600000)) - 1800000,
              $urandom_range(0, 40000), $urandom_range(0, 120000));
      send_random(230);
    end
  endtask

  // Output held off long enough to fill the pipeline and stall the input.
  task automatic test_backpressure();
    drain();
    steady_send = 1'b1;
    hold_cycles = 400;
    send_random(200);
    steady_recv = 1'b1;
    send_random(200);
    steady_recv = 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_OBS_LAT;
    cfg_data = '0;
    errors = 0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    hold_cycles = 0;
    obs_lat_reg = '0;
    obs_lon_reg = '0;
    near_reg = 18'd5000;
    approach_reg = 18'd10000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zone_edges();
    test_random_sets();
    test_backpressure();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
